FILE: rtl/tte_pkg.sv
// shared constants, types and helper function of the timer table engine
`default_nettype none
package tte_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ID_LIMIT    = 8192;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 14;
    localparam int ID_MOD_W    = $clog2(ID_LIMIT);
    localparam int TIME_W      = 32;
    localparam int KIND_W      = 8;
    localparam int WAIT_W      = 31;
    localparam int REM_W       = 40;
    localparam int HUNDREDTHS  = 100;

    typedef logic [2:0] op_t;
    localparam op_t OP_SET_REL   = 3'd0;
    localparam op_t OP_SET_ABS   = 3'd1;
    localparam op_t OP_ACK       = 3'd2;
    localparam op_t OP_DEL_ID    = 3'd3;
    localparam op_t OP_DEL_TRANS = 3'd4;
    localparam op_t OP_CHECK     = 3'd5;
    localparam op_t OP_REMAIN    = 3'd6;
    localparam op_t OP_GET       = 3'd7;

    typedef logic [1:0] status_t;
    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_INVALID = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] trans;
        logic [KIND_W-1:0] kind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // lowest clear bit of the occupancy mask
    function automatic logic [ADDR_W-1:0] first_zero(input logic [TABLE_DEPTH-1:0] mask);
        logic [ADDR_W-1:0] k;
        k = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!mask[i])
            begin
                k = ADDR_W'(i);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tte_req_if.sv
// request channel of the timer table engine
`default_nettype none
interface tte_req_if;
    import tte_pkg::*;
    logic                valid;
    logic                ready;
    logic [2:0]          operation;
    logic [TIME_W-1:0]   now_seconds;
    logic [TIME_W-1:0]   time_value;
    logic                repeat_req;
    logic [TIME_W-1:0]   transaction;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     target_id;
    logic [WAIT_W-1:0]   wait_cap;

    modport source (output valid, operation, now_seconds, time_value, repeat_req,
                    transaction, kind, target_id, wait_cap, input ready);
    modport sink (input valid, operation, now_seconds, time_value, repeat_req,
                  transaction, kind, target_id, wait_cap, output ready);
endinterface
`default_nettype wire

FILE: rtl/tte_rsp_if.sv
// response channel of the timer table engine
`default_nettype none
interface tte_rsp_if;
    import tte_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [ID_W-1:0]         result_id;
    logic signed [REM_W-1:0] remaining;
    logic [KIND_W-1:0]       kind_out;

    modport source (output valid, status, result_id, remaining, kind_out, input ready);
    modport sink (input valid, status, result_id, remaining, kind_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/tte_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/timer_table_engine.sv
// timer table engine top level: scan sequencer around the entry ram
//
// channel  dir  beat contents
// req      in   operation, now_seconds, time_value, repeat_req, transaction,
//                kind, target_id, wait_cap
// rsp      out  status, result_id, remaining, kind_out
//
// an item scans the table with one ram read per entry, then a drain step, eval and
// done; a hit stops the scan early
// removal adds a copy pass that moves each entry after the removed one down one slot
// rejected items (full table, zero id or tag) go straight to done without a scan
// reset empties the table and clears the id counter; ram contents stay undefined
// req is taken while a result still waits in the rsp register; done holds until it leaves
`default_nettype none
module timer_table_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    tte_req_if.sink   req,
    tte_rsp_if.source rsp
);
    import tte_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ID_W-1:0]        last_reg, last_next;
    logic [CNT_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                   rvalid_reg, rvalid_next;
    logic                   out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    op_t                    op_reg, op_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [TIME_W-1:0]      tval_reg, tval_next;
    logic                   rep_reg, rep_next;
    logic [TIME_W-1:0]      trans_reg, trans_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [ID_W-1:0]        tid_reg, tid_next;
    logic [WAIT_W-1:0]      maxw_reg, maxw_next;
    logic                   found_reg, found_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    entry_t                 hit_reg, hit_next;
    logic [TABLE_DEPTH-1:0] occ_reg, occ_next;
    logic [TIME_W-1:0]      min_reg, min_next;
    logic                   have_min_reg, have_min_next;
    status_t                status_reg, status_next;
    logic [ID_W-1:0]        rid_reg, rid_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [KIND_W-1:0]      kout_reg, kout_next;
    status_t                o_status_reg, o_status_next;
    logic [ID_W-1:0]        o_rid_reg, o_rid_next;
    logic [REM_W-1:0]       o_rem_reg, o_rem_next;
    logic [KIND_W-1:0]      o_kout_reg, o_kout_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    entry_t                 rd_entry;
    entry_t                 new_entry;
    logic [ID_MOD_W-1:0]    id_gap;
    logic [ADDR_W-1:0]      alloc_k;
    logic [ID_W-1:0]        alloc_id;
    logic [TIME_W-1:0]      diff;
    logic [REM_W-1:0]       prod;
    logic                   accept;

    tte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign ram_raddr = rd_ptr_reg[ADDR_W-1:0];
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = o_status_reg;
    assign rsp.result_id = o_rid_reg;
    assign rsp.remaining = o_rem_reg;
    assign rsp.kind_out  = o_kout_reg;

    // distance of a stored id from the id after the last issued one, modulo ID_LIMIT
    assign id_gap   = ID_MOD_W'(rd_entry.id - ID_W'(1) - last_reg);
    assign alloc_k  = first_zero(occ_reg);
    assign alloc_id = ID_W'(ID_MOD_W'(last_reg + ID_W'(alloc_k))) + ID_W'(1);
    assign diff     = rd_entry.expiry - now_reg;
    assign prod     = REM_W'(min_reg) * REM_W'(HUNDREDTHS);

    always_comb
    begin
        new_entry.id     = (count_reg == '0) ? ID_W'(1) : alloc_id;
        new_entry.expiry = (op_reg == OP_SET_REL) ? now_reg + tval_reg : tval_reg;
        new_entry.period = (op_reg == OP_SET_REL && rep_reg) ? tval_reg : '0;
        new_entry.trans  = trans_reg;
        new_entry.kind   = kind_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        rd_ptr_next    = rd_ptr_reg;
        rvalid_next    = rvalid_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rd_idx_next    = rd_idx_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        tval_next      = tval_reg;
        rep_next       = rep_reg;
        trans_next     = trans_reg;
        kind_next      = kind_reg;
        tid_next       = tid_reg;
        maxw_next      = maxw_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        occ_next       = occ_reg;
        min_next       = min_reg;
        have_min_next  = have_min_reg;
        status_next    = status_reg;
        rid_next       = rid_reg;
        rem_next       = rem_reg;
        kout_next      = kout_reg;
        o_status_next  = o_status_reg;
        o_rid_next     = o_rid_reg;
        o_rem_next     = o_rem_reg;
        o_kout_next    = o_kout_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = new_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = req.operation;
                    now_next      = req.now_seconds;
                    tval_next     = req.time_value;
                    rep_next      = req.repeat_req;
                    trans_next    = req.transaction;
                    kind_next     = req.kind;
                    tid_next      = req.target_id;
                    maxw_next     = req.wait_cap;
                    status_next   = ST_DONE;
                    rid_next      = '0;
                    rem_next      = '0;
                    kout_next     = '0;
                    found_next    = 1'b0;
                    occ_next      = '0;
                    have_min_next = 1'b0;
                    rd_ptr_next   = '0;
                    rvalid_next   = 1'b0;
                    state_next    = S_SCAN;
                    case (req.operation) inside
                        OP_SET_REL, OP_SET_ABS:
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                        end
                        OP_ACK, OP_DEL_ID, OP_GET:
                        begin
                            if (req.target_id == '0)
                            begin
                                status_next = ST_INVALID;
                                state_next  = S_DONE;
                            end
                        end
                        OP_DEL_TRANS:
                        begin
                            if (req.transaction == '0)
                            begin
                                status_next = ST_INVALID;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    rvalid_next = 1'b1;
                    rd_idx_next = rd_ptr_reg;
                end
                else
                begin
                    rvalid_next = 1'b0;
                    if (!rvalid_reg)
                    begin
                        state_next = S_EVAL;
                    end
                end
                if (rvalid_reg)
                begin
                    case (op_reg) inside
                        OP_SET_REL, OP_SET_ABS:
                        begin
                            if (id_gap < ID_MOD_W'(TABLE_DEPTH))
                            begin
                                occ_next[id_gap[ADDR_W-1:0]] = 1'b1;
                            end
                        end
                        OP_ACK, OP_DEL_ID, OP_GET:
                        begin
                            found_next = (rd_entry.id == tid_reg);
                        end
                        OP_DEL_TRANS:
                        begin
                            found_next = (rd_entry.trans == trans_reg);
                        end
                        default:
                        begin
                            found_next = (rd_entry.expiry <= now_reg);
                            if (op_reg == OP_REMAIN && !(rd_entry.expiry <= now_reg)
                                && (!have_min_reg || diff < min_reg))
                            begin
                                min_next      = diff;
                                have_min_next = 1'b1;
                            end
                        end
                    endcase
                    if (found_next)
                    begin
                        pos_next    = rd_idx_reg[ADDR_W-1:0];
                        hit_next    = rd_entry;
                        rvalid_next = 1'b0;
                        state_next  = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                state_next  = S_DONE;
                rvalid_next = 1'b0;
                case (op_reg) inside
                    OP_SET_REL, OP_SET_ABS:
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[ADDR_W-1:0];
                        ram_wdata  = new_entry;
                        count_next = count_reg + CNT_W'(1);
                        last_next  = new_entry.id;
                        rid_next   = new_entry.id;
                    end
                    OP_ACK, OP_DEL_ID, OP_GET, OP_DEL_TRANS:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (op_reg == OP_GET)
                        begin
                            kout_next = hit_reg.kind;
                        end
                        else if (op_reg == OP_ACK && hit_reg.period != '0)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg;
                            ram_wdata = {hit_reg.id, hit_reg.expiry + hit_reg.period,
                                         hit_reg.period, hit_reg.trans, hit_reg.kind};
                        end
                        else
                        begin
                            rd_ptr_next = CNT_W'(pos_reg) + CNT_W'(1);
                            state_next  = S_SHIFT;
                        end
                    end
                    OP_CHECK:
                    begin
                        rid_next = found_reg ? hit_reg.id : '0;
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            rem_next = '1;
                        end
                        else if (found_reg)
                        begin
                            rem_next = '0;
                        end
                        else if (maxw_reg != '0 && prod > REM_W'(maxw_reg))
                        begin
                            rem_next = REM_W'(maxw_reg);
                        end
                        else
                        begin
                            rem_next = prod;
                        end
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    rvalid_next = 1'b1;
                    rd_idx_next = rd_ptr_reg;
                end
                else
                begin
                    rvalid_next = 1'b0;
                    if (!rvalid_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
                if (rvalid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(rd_idx_reg - CNT_W'(1));
                    ram_wdata = ram_rdata;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_rid_next     = rid_reg;
                    o_rem_next     = rem_reg;
                    o_kout_next    = kout_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            rd_ptr_reg    <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            rd_ptr_reg    <= rd_ptr_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        op_reg       <= op_next;
        now_reg      <= now_next;
        tval_reg     <= tval_next;
        rep_reg      <= rep_next;
        trans_reg    <= trans_next;
        kind_reg     <= kind_next;
        tid_reg      <= tid_next;
        maxw_reg     <= maxw_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        hit_reg      <= hit_next;
        occ_reg      <= occ_next;
        min_reg      <= min_next;
        have_min_reg <= have_min_next;
        status_reg   <= status_next;
        rid_reg      <= rid_next;
        rem_reg      <= rem_next;
        kout_reg     <= kout_next;
        o_status_reg <= o_status_next;
        o_rid_reg    <= o_rid_next;
        o_rem_reg    <= o_rem_next;
        o_kout_reg   <= o_kout_next;
    end

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            count_reg == $past(count_reg) + CNT_W'(1) ||
            count_reg == $past(count_reg) - CNT_W'(1))
        else $error("entry count jumped");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> CNT_W'(ram_waddr) <= count_reg)
        else $error("ram write beyond table");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> count_reg != '0)
        else $error("removal on empty table");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted beat not started");
endmodule
`default_nettype wire
